FILE: design/wbpbp_pkg.sv
`timescale 1ns / 1ps

package wbpbp_pkg;

  localparam int FRAME_COUNT_DEF  = 4;
  localparam int PAGE_BYTES       = 4;
  localparam int PAGE_NUMBER_BITS = 8;

  localparam int FUNC_W  = 2;
  localparam int PAGE_W  = 8;
  localparam int VICT_W  = 4;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 3;
  localparam int FRAME_W = 4;
  localparam int BC_W    = 9;

  localparam logic [BC_W-1:0] BLOCK_COUNT_RST = 9'd5;

  localparam logic [DATA_W-1:0] DATA_MASK =
    (PAGE_BYTES >= 4) ? {DATA_W{1'b1}} : DATA_W'((64'd1 << (PAGE_BYTES * 8)) - 64'd1);
  localparam logic [PAGE_W-1:0] PAGE_MASK =
    (PAGE_NUMBER_BITS >= PAGE_W) ? {PAGE_W{1'b1}} :
    PAGE_W'((32'd1 << PAGE_NUMBER_BITS) - 32'd1);

  typedef enum logic [FUNC_W-1:0] {
    FN_FETCH    = 2'd0,
    FN_WRITE    = 2'd1,
    FN_SHUTDOWN = 2'd2,
    FN_INVALID  = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    SS_RESIDENT  = 3'd0,
    SS_LOADED    = 3'd1,
    SS_WRITTEN   = 3'd2,
    SS_BAD_PAGE  = 3'd3,
    SS_BAD_FRAME = 3'd4,
    SS_FLUSH     = 3'd5,
    SS_BAD_FUNC  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DECIDE,
    S_LOAD,
    S_FINAL
  } state_t;

endpackage

FILE: design/wbpbp_if.sv
`timescale 1ns / 1ps

interface wbpbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  page_number;
  logic [3:0]  victim_frame;
  logic [31:0] fill_data;
  logic [31:0] write_data;

  modport source (output valid, func, page_number, victim_frame, fill_data, write_data,
                  input ready);
  modport sink   (input valid, func, page_number, victim_frame, fill_data, write_data,
                  output ready);
endinterface

interface wbpbp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  frame_number;
  logic        writeback_valid;
  logic [7:0]  writeback_page;
  logic [31:0] writeback_data;
  logic        last;

  modport source (output valid, status, frame_number, writeback_valid, writeback_page,
                  writeback_data, last, input ready);
  modport sink   (input valid, status, frame_number, writeback_valid, writeback_page,
                  writeback_data, last, output ready);
endinterface

interface wbpbp_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: design/write_back_page_buffer_pool.sv
`timescale 1ns / 1ps
// Write-back page buffer pool: FRAME_COUNT frames, fully associative.
// in_ch takes one request beat (fetch, write, shutdown) when valid and ready are
// high; ready is high only while the sequencer is idle. out_ch gives result beats,
// the final beat of each request carrying last. cfg_ch writes block_count and is
// always ready; the user must write it only while the pool is idle, which the
// block itself does not enforce.
// Sequence: a check state for the request, then a scan of one frame per cycle
// over a single tag compare and frame read port (held only while a shutdown flush
// beat waits on the receiver), then a decide state and a load/update state. A load
// or a write answers from the load state; a resident page, a bad victim or a write
// to a page not held answers from the decide state. Bad page and bad function
// answer from the check state. Shutdown gives one beat per dirty frame during the
// scan and its final beat from a final state after the scan.
// The result sits in an output register; a stalled receiver holds the sequencer
// wherever it next needs to emit a beat, and nothing is lost.
// Reset (rst_n low at a clock edge) frees every frame, clears dirty marks and sets
// block_count to 5.
module write_back_page_buffer_pool #(
  parameter int FRAME_COUNT = wbpbp_pkg::FRAME_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  wbpbp_in_if.sink      in_ch,
  wbpbp_out_if.source   out_ch,
  wbpbp_cfg_if.sink     cfg_ch
);
  import wbpbp_pkg::*;

  localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_COUNT - 1);

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic [FUNC_W-1:0] func_r;
  logic [PAGE_W-1:0] page_r;
  logic [VICT_W-1:0] victim_r;
  logic [DATA_W-1:0] fill_r;
  logic [DATA_W-1:0] wdata_r;

  logic             hit_r, free_r;
  logic [IDX_W-1:0] hit_idx_r, free_idx_r;
  logic [BC_W-1:0]  bc_r;

  logic [FRAME_COUNT-1:0] in_use_r, dirty_r;
  logic [PAGE_W-1:0]      page_mem [FRAME_COUNT];
  logic [DATA_W-1:0]      data_mem [FRAME_COUNT];

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [FRAME_W-1:0] out_frame_r;
  logic              out_wb_r;
  logic [PAGE_W-1:0] out_wb_page_r;
  logic [DATA_W-1:0] out_wb_data_r;
  logic              out_last_r;

  logic in_fire, out_free;
  logic cur_use, cur_dirty, cur_match, flush_hit, victim_bad;

  // control from the output block
  logic              emit;
  logic [STAT_W-1:0] e_status;
  logic [FRAME_W-1:0] e_frame;
  logic              e_wb;
  logic [PAGE_W-1:0] e_wb_page;
  logic [DATA_W-1:0] e_wb_data;
  logic              e_last;
  logic              mem_we;
  logic [DATA_W-1:0] mem_wdata;
  logic              page_we;
  logic              set_use, clr_use, set_dirty, clr_dirty;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign cur_use    = in_use_r[idx_r];
  assign cur_dirty  = dirty_r[idx_r];
  assign cur_match  = cur_use && (page_mem[idx_r] == page_r);
  assign flush_hit  = cur_use && cur_dirty;
  assign victim_bad = ({1'b0, victim_r} >= (VICT_W + 1)'(FRAME_COUNT));

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        idx_nxt = '0;
        if (func_r == FN_INVALID ||
            (func_r == FN_FETCH && {1'b0, page_r} >= bc_r)) begin
          if (out_free) state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!(func_r == FN_SHUTDOWN && flush_hit && !out_free)) begin
          if (idx_r == IDX_LAST) begin
            state_nxt = (func_r == FN_SHUTDOWN) ? S_FINAL : S_DECIDE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_DECIDE: begin
        if (func_r == FN_FETCH) begin
          if (hit_r) begin
            if (out_free) state_nxt = S_IDLE;
          end else if (free_r) begin
            idx_nxt   = free_idx_r;
            state_nxt = S_LOAD;
          end else if (victim_bad) begin
            if (out_free) state_nxt = S_IDLE;
          end else begin
            idx_nxt   = victim_r[IDX_W-1:0];
            state_nxt = S_LOAD;
          end
        end else if (hit_r) begin
          idx_nxt   = hit_idx_r;
          state_nxt = S_LOAD;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_LOAD: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_FINAL: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and frame updates
  always_comb begin
    emit      = 1'b0;
    e_status  = SS_FLUSH;
    e_frame   = '0;
    e_wb      = 1'b0;
    e_wb_page = '0;
    e_wb_data = '0;
    e_last    = 1'b1;
    mem_we    = 1'b0;
    mem_wdata = fill_r;
    page_we   = 1'b0;
    set_use   = 1'b0;
    clr_use   = 1'b0;
    set_dirty = 1'b0;
    clr_dirty = 1'b0;
    case (state_r)
      S_CHECK: begin
        if (func_r == FN_INVALID) begin
          emit     = out_free;
          e_status = SS_BAD_FUNC;
        end else if (func_r == FN_FETCH && {1'b0, page_r} >= bc_r) begin
          emit     = out_free;
          e_status = SS_BAD_PAGE;
        end
      end
      S_SCAN: begin
        if (func_r == FN_SHUTDOWN && flush_hit && out_free) begin
          emit      = 1'b1;
          e_status  = SS_FLUSH;
          e_frame   = FRAME_W'(idx_r);
          e_wb      = 1'b1;
          e_wb_page = page_mem[idx_r];
          e_wb_data = data_mem[idx_r];
          e_last    = 1'b0;
          clr_use   = 1'b1;
          clr_dirty = 1'b1;
        end
      end
      S_DECIDE: begin
        if (func_r == FN_FETCH) begin
          if (hit_r) begin
            emit     = out_free;
            e_status = SS_RESIDENT;
            e_frame  = FRAME_W'(hit_idx_r);
          end else if (!free_r && victim_bad) begin
            emit     = out_free;
            e_status = SS_BAD_FRAME;
          end
        end else if (!hit_r) begin
          emit     = out_free;
          e_status = SS_BAD_FRAME;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          emit    = 1'b1;
          e_frame = FRAME_W'(idx_r);
          mem_we  = 1'b1;
          if (func_r == FN_FETCH) begin
            e_status = SS_LOADED;
            // victim write-back rides on the load beat
            if (cur_use && cur_dirty) begin
              e_wb      = 1'b1;
              e_wb_page = page_mem[idx_r];
              e_wb_data = data_mem[idx_r];
            end
            mem_wdata = fill_r;
            page_we   = 1'b1;
            set_use   = 1'b1;
            clr_dirty = 1'b1;
          end else begin
            e_status  = SS_WRITTEN;
            mem_wdata = wdata_r;
            set_dirty = 1'b1;
          end
        end
      end
      S_FINAL: begin
        emit     = out_free;
        e_status = SS_FLUSH;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      bc_r        <= BLOCK_COUNT_RST;
      in_use_r    <= '0;
      dirty_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (cfg_ch.valid && cfg_ch.ready) bc_r <= cfg_ch.data;

      if (state_r == S_CHECK) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (state_r == S_SCAN && func_r != FN_SHUTDOWN) begin
        if (cur_match && !hit_r) hit_r <= 1'b1;
        if (!cur_use && !free_r) free_r <= 1'b1;
      end

      if (set_use) in_use_r[idx_r] <= 1'b1;
      if (clr_use) in_use_r[idx_r] <= 1'b0;
      if (set_dirty) dirty_r[idx_r] <= 1'b1;
      if (clr_dirty) dirty_r[idx_r] <= 1'b0;

      if (emit) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // payload and frame store, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r   <= in_ch.func;
      page_r   <= in_ch.page_number & PAGE_MASK;
      victim_r <= in_ch.victim_frame;
      fill_r   <= in_ch.fill_data & DATA_MASK;
      wdata_r  <= in_ch.write_data & DATA_MASK;
    end
    if (state_r == S_SCAN && func_r != FN_SHUTDOWN) begin
      if (cur_match && !hit_r) hit_idx_r <= idx_r;
      if (!cur_use && !free_r) free_idx_r <= idx_r;
    end
    if (mem_we) data_mem[idx_r] <= mem_wdata;
    if (page_we) page_mem[idx_r] <= page_r;
    if (emit) begin
      out_status_r  <= e_status;
      out_frame_r   <= e_frame;
      out_wb_r      <= e_wb;
      out_wb_page_r <= e_wb_page;
      out_wb_data_r <= e_wb_data;
      out_last_r    <= e_last;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.frame_number    = out_frame_r;
  assign out_ch.writeback_valid = out_wb_r;
  assign out_ch.writeback_page  = out_wb_page_r;
  assign out_ch.writeback_data  = out_wb_data_r;
  assign out_ch.last            = out_last_r;

  a_dirty_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (dirty_r & ~in_use_r) == '0)
    else $error("dirty mark on a free frame");

  a_wb_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_wb_r) |-> (out_status_r == SS_LOADED || out_status_r == SS_FLUSH))
    else $error("write-back on a result that cannot carry one");

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_CHECK))
    else $error("request beat not followed by check");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result overwrote a waiting beat");

endmodule
